FILE: hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs, msg)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg)
`endif

`endif

FILE: hw/rtl/pfgb_pkg.sv
package pfgb_pkg;

    localparam int SCREEN_COLS = 128;
    localparam int SCREEN_ROWS = 64;
    localparam int FONT_GLYPHS = 128;
    localparam int FIRST_CODE  = 33;
    localparam int CELL        = 8;
    localparam int STORE_DEPTH = 1024;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    typedef logic [STORE_AW-1:0] store_addr_t;
    typedef logic [7:0]          byte_t;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_DRAW = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_OFFSCR  = 2'd1;
    localparam logic [1:0] STATUS_NOGLYPH = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [6:0] pos_x;
        logic [5:0] pos_y;
        logic [9:0] font_addr;
        logic [7:0] font_byte;
        logic [9:0] fb_addr;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
    } rsp_t;

endpackage

FILE: hw/rtl/pfgb_ram.sv
module pfgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/page_framebuffer_glyph_blit_core.sv
// page-mode monochrome framebuffer with an 8x8 character blitter
//
// req channel (valid/ready) carries one request transaction: load a font
// byte, draw a character at (pos_x, pos_y), or read a framebuffer byte.
// rsp channel (valid/ready) returns exactly one transaction per request,
// in request order, with read_data (reads only) and status.
// a draw touches one page, or two when pos_y is not a multiple of 8. the
// framebuffer memory has a single port, so each read-modify-write of a
// column byte goes through a read state (ST_DRRD) and then a write state
// (ST_DRWR); 8 columns per page touched.
// one request is in flight at a time; a new request is taken once the
// previous one has moved into the response register, so the next request
// can start while a response still waits for rsp_ready.
// after reset the framebuffer is cleared one byte a cycle, all 1024 bytes,
// during which req_ready stays low. the font store is not cleared.
// a stalled receiver holds the response; the block then waits with the
// next result until the response register frees up.
module page_framebuffer_glyph_blit_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  pfgb_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output pfgb_pkg::rsp_t   rsp
);

    `include "assert_macros.svh"

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RDWT  = 3'd2;
    localparam logic [2:0] ST_DRRD  = 3'd3;
    localparam logic [2:0] ST_DRWR  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]            state_reg, state_next;
    pfgb_pkg::store_addr_t clr_addr_reg, clr_addr_next;
    logic [2:0]            col_reg, col_next;
    logic                  page2_reg, page2_next;
    pfgb_pkg::store_addr_t base_reg, base_next;
    pfgb_pkg::store_addr_t glyph_base_reg, glyph_base_next;
    logic [2:0]            shift_reg, shift_next;
    pfgb_pkg::byte_t       pend_data_reg, pend_data_next;
    logic [1:0]            pend_status_reg, pend_status_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    pfgb_pkg::rsp_t        rsp_reg, rsp_next;

    logic                  frame_we;
    pfgb_pkg::store_addr_t frame_addr;
    pfgb_pkg::byte_t       frame_wdata;
    pfgb_pkg::byte_t       frame_rdata;
    logic                  glyph_we;
    pfgb_pkg::store_addr_t glyph_addr;
    pfgb_pkg::byte_t       glyph_rdata;

    logic                  accept;
    logic                  rsp_free;
    logic                  off_screen;
    logic                  no_glyph;
    pfgb_pkg::byte_t       glyph_idx;
    pfgb_pkg::store_addr_t draw_addr;
    pfgb_pkg::byte_t       keep;
    pfgb_pkg::byte_t       merged;

    pfgb_ram #(
        .WIDTH (8),
        .DEPTH (pfgb_pkg::STORE_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .addr  (frame_addr),
        .wdata (frame_wdata),
        .rdata (frame_rdata)
    );

    pfgb_ram #(
        .WIDTH (8),
        .DEPTH (pfgb_pkg::STORE_DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (glyph_we),
        .addr  (glyph_addr),
        .wdata (req.font_byte),
        .rdata (glyph_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign off_screen = ({1'b0, req.pos_x} > 8'(pfgb_pkg::SCREEN_COLS - pfgb_pkg::CELL))
                     || ({2'b00, req.pos_y} > 8'(pfgb_pkg::SCREEN_ROWS - pfgb_pkg::CELL));
    assign no_glyph   = ({1'b0, req.char_code} < 9'(pfgb_pkg::FIRST_CODE))
                     || ({1'b0, req.char_code}
                         >= 9'(pfgb_pkg::FIRST_CODE + pfgb_pkg::FONT_GLYPHS));
    assign glyph_idx  = req.char_code - 8'(pfgb_pkg::FIRST_CODE);

    assign draw_addr = base_reg
                     + (page2_reg ? pfgb_pkg::store_addr_t'(pfgb_pkg::SCREEN_COLS)
                                  : pfgb_pkg::store_addr_t'(0))
                     + pfgb_pkg::store_addr_t'(col_reg);

    // rows above the cell in the upper page, below it in the lower page
    assign keep = 8'hFF >> (4'(pfgb_pkg::CELL) - {1'b0, shift_reg});

    always_comb
    begin
        if (page2_reg)
        begin
            merged = (frame_rdata & ~keep)
                   | pfgb_pkg::byte_t'(glyph_rdata >> (4'(pfgb_pkg::CELL) - {1'b0, shift_reg}));
        end
        else
        begin
            merged = (frame_rdata & keep)
                   | pfgb_pkg::byte_t'({8'h00, glyph_rdata} << shift_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        col_next         = col_reg;
        page2_next       = page2_reg;
        base_next        = base_reg;
        glyph_base_next  = glyph_base_reg;
        shift_next       = shift_reg;
        pend_data_next   = pend_data_reg;
        pend_status_next = pend_status_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;

        frame_we    = 1'b0;
        frame_addr  = draw_addr;
        frame_wdata = merged;
        glyph_we    = 1'b0;
        glyph_addr  = glyph_base_reg + pfgb_pkg::store_addr_t'(col_reg);

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                frame_we      = 1'b1;
                frame_addr    = clr_addr_reg;
                frame_wdata   = '0;
                clr_addr_next = clr_addr_reg + pfgb_pkg::store_addr_t'(1);
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                frame_addr = req.fb_addr;
                if (accept)
                begin
                    pend_data_next   = '0;
                    pend_status_next = pfgb_pkg::STATUS_DONE;
                    state_next       = ST_FIN;
                    case (req.req_type)
                        pfgb_pkg::REQ_LOAD:
                        begin
                            glyph_we   = 1'b1;
                            glyph_addr = req.font_addr;
                        end
                        pfgb_pkg::REQ_DRAW:
                        begin
                            if (off_screen)
                            begin
                                pend_status_next = pfgb_pkg::STATUS_OFFSCR;
                            end
                            else if (no_glyph)
                            begin
                                pend_status_next = pfgb_pkg::STATUS_NOGLYPH;
                            end
                            else
                            begin
                                base_next = pfgb_pkg::store_addr_t'(
                                    pfgb_pkg::store_addr_t'(req.pos_y >> 3)
                                    * pfgb_pkg::store_addr_t'(pfgb_pkg::SCREEN_COLS))
                                    + pfgb_pkg::store_addr_t'(req.pos_x);
                                glyph_base_next = pfgb_pkg::store_addr_t'(
                                    pfgb_pkg::store_addr_t'(glyph_idx) << 3);
                                shift_next = req.pos_y[2:0];
                                col_next   = '0;
                                page2_next = 1'b0;
                                state_next = ST_DRRD;
                            end
                        end
                        pfgb_pkg::REQ_READ:
                        begin
                            state_next = ST_RDWT;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RDWT:
            begin
                pend_data_next = frame_rdata;
                state_next     = ST_FIN;
            end
            ST_DRRD:
            begin
                state_next = ST_DRWR;
            end
            ST_DRWR:
            begin
                frame_we = 1'b1;
                col_next = col_reg + 3'd1;
                if (&col_reg)
                begin
                    if (!page2_reg && (shift_reg != 3'd0))
                    begin
                        page2_next = 1'b1;
                        state_next = ST_DRRD;
                    end
                    else
                    begin
                        page2_next = 1'b0;
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    state_next = ST_DRRD;
                end
            end
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.read_data = pend_data_reg;
                    rsp_next.status    = pend_status_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            col_reg       <= '0;
            page2_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            col_reg       <= col_next;
            page2_reg     <= page2_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg        <= base_next;
        glyph_base_reg  <= glyph_base_next;
        shift_reg       <= shift_next;
        pend_data_reg   <= pend_data_next;
        pend_status_reg <= pend_status_next;
        rsp_reg         <= rsp_next;
    end

    `ASSERT_IMPLIES(a_idle_no_frame_write, clk, rst_n,
        (state_reg == ST_IDLE), !frame_we, "framebuffer written while idle")
    `ASSERT_IMPLIES(a_rmw_same_addr, clk, rst_n,
        (state_reg == ST_DRWR), (frame_addr == $past(frame_addr)),
        "draw write address differs from its read address")
    `ASSERT_IMPLIES(a_rsp_from_fin, clk, rst_n,
        $rose(rsp_valid_reg), ($past(state_reg) == ST_FIN),
        "response raised outside finish state")
    `ASSERT_IMPLIES(a_page2_needs_shift, clk, rst_n,
        (page2_reg && ((state_reg == ST_DRRD) || (state_reg == ST_DRWR))),
        (shift_reg != 3'd0), "second page drawn for an aligned row")
    `ASSERT_NEXT(a_fin_full_rsp, clk, rst_n,
        ((state_reg == ST_FIN) && rsp_free), (rsp_valid_reg && (state_reg == ST_IDLE)),
        "finish did not hand over a response")

endmodule

FILE: dv/page_framebuffer_glyph_blit_core_test.sv
module page_framebuffer_glyph_blit_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 1100;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        pfgb_pkg::req_t rq;
        logic           fixed;
        pfgb_pkg::rsp_t want;
    } step_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    pfgb_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    pfgb_pkg::rsp_t rsp;

    pfgb_pkg::byte_t fb_image [pfgb_pkg::STORE_DEPTH];
    pfgb_pkg::byte_t font_image [pfgb_pkg::STORE_DEPTH];
    bit              font_written [pfgb_pkg::STORE_DEPTH];

    pfgb_pkg::rsp_t rsp_due [$];
    pfgb_pkg::rsp_t rsp_head;
    int   fails;
    int   mismatches;
    int   cycles;
    int   sent;
    bit   steady;
    int   hold_asked;
    int   hold_served;
    int   hold_left;
    int   stall_left;
    int   rx_gap;

    page_framebuffer_glyph_blit_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("page_framebuffer_glyph_blit_core_test: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic pfgb_pkg::req_t noise_request();
        pfgb_pkg::req_t r;
        r.req_type  = 2'($urandom);
        r.char_code = 8'($urandom);
        r.pos_x     = 7'($urandom);
        r.pos_y     = 6'($urandom);
        r.font_addr = 10'($urandom);
        r.font_byte = 8'($urandom);
        r.fb_addr   = 10'($urandom);
        return r;
    endfunction

    function automatic step_t row(logic [1:0] typ, int code, int x, int y, int faddr,
                                  int fbyte, int raddr, bit fixed, int rdata,
                                  logic [1:0] stat);
        step_t s;
        s.rq.req_type       = typ;
        s.rq.char_code      = 8'(code);
        s.rq.pos_x          = 7'(x);
        s.rq.pos_y          = 6'(y);
        s.rq.font_addr      = 10'(faddr);
        s.rq.font_byte      = 8'(fbyte);
        s.rq.fb_addr        = 10'(raddr);
        s.fixed             = fixed;
        s.want.read_data    = 8'(rdata);
        s.want.status       = stat;
        return s;
    endfunction

    // page-mode framebuffer and font store, updated in request order
    function automatic pfgb_pkg::rsp_t service_request(pfgb_pkg::req_t r);
        pfgb_pkg::rsp_t  o;
        int unsigned     glyph;
        int unsigned     base;
        int unsigned     shift;
        int unsigned     a;
        pfgb_pkg::byte_t keep;
        pfgb_pkg::byte_t g;
        o.read_data = '0;
        o.status    = pfgb_pkg::STATUS_DONE;
        case (r.req_type)
            pfgb_pkg::REQ_LOAD:
            begin
                font_image[r.font_addr]   = r.font_byte;
                font_written[r.font_addr] = 1'b1;
            end
            pfgb_pkg::REQ_DRAW:
            begin
                if (r.pos_x > pfgb_pkg::SCREEN_COLS - pfgb_pkg::CELL
                    || r.pos_y > pfgb_pkg::SCREEN_ROWS - pfgb_pkg::CELL)
                    o.status = pfgb_pkg::STATUS_OFFSCR;
                else if (r.char_code < pfgb_pkg::FIRST_CODE
                         || r.char_code >= pfgb_pkg::FIRST_CODE + pfgb_pkg::FONT_GLYPHS)
                    o.status = pfgb_pkg::STATUS_NOGLYPH;
                else
                begin
                    glyph = (r.char_code - pfgb_pkg::FIRST_CODE) * pfgb_pkg::CELL;
                    base  = (r.pos_y >> 3) * pfgb_pkg::SCREEN_COLS + r.pos_x;
                    shift = r.pos_y % pfgb_pkg::CELL;
                    keep  = pfgb_pkg::byte_t'(16'h00FF >> (pfgb_pkg::CELL - shift));
                    for (int col = 0; col < pfgb_pkg::CELL; col++)
                    begin
                        a = (base + col) % pfgb_pkg::STORE_DEPTH;
                        g = font_image[(glyph + col) % pfgb_pkg::STORE_DEPTH];
                        fb_image[a] = (fb_image[a] & keep) | pfgb_pkg::byte_t'(g << shift);
                    end
                    if (shift != 0)
                    begin
                        base += pfgb_pkg::SCREEN_COLS;
                        for (int col = 0; col < pfgb_pkg::CELL; col++)
                        begin
                            a = (base + col) % pfgb_pkg::STORE_DEPTH;
                            g = font_image[(glyph + col) % pfgb_pkg::STORE_DEPTH];
                            fb_image[a] = (fb_image[a] & ~keep)
                                        | pfgb_pkg::byte_t'(g >> (pfgb_pkg::CELL - shift));
                        end
                    end
                end
            end
            pfgb_pkg::REQ_READ:
                o.read_data = fb_image[r.fb_addr];
            default:
                ;
        endcase
        return o;
    endfunction

    task automatic drive_item(input pfgb_pkg::req_t r, input bit fixed,
                              input pfgb_pkg::rsp_t want);
        pfgb_pkg::rsp_t model_rsp;
        int             gap;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        model_rsp = service_request(r);
        rsp_due.push_back(fixed ? want : model_rsp);
        sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // response side: check each transaction, then decide next ready
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (rsp_due.size() == 0)
            begin
                fails++;
                if (mismatches < 10)
                    $display("unexpected transaction: read_data %02h status %0d",
                             rsp.read_data, rsp.status);
                mismatches++;
            end
            else
            begin
                rsp_head = rsp_due.pop_front();
                if (rsp.read_data !== rsp_head.read_data || rsp.status !== rsp_head.status)
                begin
                    fails++;
                    if (mismatches < 10)
                        $display("mismatch: read_data exp %02h got %02h, status exp %0d got %0d",
                                 rsp_head.read_data, rsp.read_data, rsp_head.status, rsp.status);
                    mismatches++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
        end
        else if (steady)
            rsp_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rx_gap = pick_gap();
            if (rx_gap == 0)
                rsp_ready <= 1'b1;
            else
            begin
                stall_left = rx_gap - 1;
                rsp_ready <= 1'b0;
            end
        end
    end

    initial
    begin
        step_t          script [$];
        pfgb_pkg::req_t r;
        pfgb_pkg::req_t ld;
        int             kind;
        int             pick;
        int             idx;
        int             last_base;
        bit             held;
        bit             paused;

        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b0;
        fails       = 0;
        mismatches  = 0;
        cycles      = 0;
        sent        = 0;
        steady      = 1'b0;
        hold_asked  = 0;
        hold_served = 0;
        hold_left   = 0;
        stall_left  = 0;
        last_base   = 0;
        held        = 1'b0;
        paused      = 1'b0;
        for (int i = 0; i < pfgb_pkg::STORE_DEPTH; i++)
        begin
            fb_image[i]     = '0;
            font_image[i]   = '0;
            font_written[i] = 1'b0;
        end

        // cleared framebuffer, unused request, skipped draws
        script.push_back(row(pfgb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_READ, 0, 0, 0, 0, 0, 1023, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(REQ_UNUSED, 255, 127, 63, 1023, 255, 1023, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_DRAW, 65, 121, 0, 0, 0, 0, 1, 0,
                             pfgb_pkg::STATUS_OFFSCR));
        script.push_back(row(pfgb_pkg::REQ_DRAW, 65, 0, 57, 0, 0, 0, 1, 0,
                             pfgb_pkg::STATUS_OFFSCR));
        script.push_back(row(pfgb_pkg::REQ_DRAW, 32, 127, 63, 0, 0, 0, 1, 0,
                             pfgb_pkg::STATUS_OFFSCR));
        script.push_back(row(pfgb_pkg::REQ_DRAW, 32, 0, 0, 0, 0, 0, 1, 0,
                             pfgb_pkg::STATUS_NOGLYPH));
        script.push_back(row(pfgb_pkg::REQ_DRAW, 161, 120, 56, 0, 0, 0, 1, 0,
                             pfgb_pkg::STATUS_NOGLYPH));
        script.push_back(row(pfgb_pkg::REQ_DRAW, 255, 0, 0, 0, 0, 0, 1, 0,
                             pfgb_pkg::STATUS_NOGLYPH));
        script.push_back(row(pfgb_pkg::REQ_DRAW, 0, 0, 0, 0, 0, 0, 1, 0,
                             pfgb_pkg::STATUS_NOGLYPH));
        // glyph for the first code, plus the top font entry
        script.push_back(row(pfgb_pkg::REQ_LOAD, 0, 0, 0, 0, 8'hFF, 0, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_LOAD, 0, 0, 0, 1, 8'h01, 0, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_LOAD, 0, 0, 0, 2, 8'h80, 0, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_LOAD, 0, 0, 0, 3, 8'h55, 0, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_LOAD, 0, 0, 0, 4, 8'hAA, 0, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_LOAD, 0, 0, 0, 5, 8'h0F, 0, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_LOAD, 0, 0, 0, 6, 8'hF0, 0, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_LOAD, 0, 0, 0, 7, 8'h3C, 0, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_LOAD, 0, 0, 0, 1023, 8'hA5, 0, 1, 0,
                             pfgb_pkg::STATUS_DONE));
        // draws at the corners and across a page boundary
        script.push_back(row(pfgb_pkg::REQ_DRAW, pfgb_pkg::FIRST_CODE, 0, 0, 0, 0, 0, 0, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_DRAW, pfgb_pkg::FIRST_CODE, 120, 56, 0, 0, 0, 0, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_DRAW, pfgb_pkg::FIRST_CODE, 3, 5, 0, 0, 0, 0, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_READ, 0, 0, 0, 0, 0, 3, 0, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_READ, 0, 0, 0, 0, 0, 128 + 3, 0, 0,
                             pfgb_pkg::STATUS_DONE));
        script.push_back(row(pfgb_pkg::REQ_READ, 0, 0, 0, 0, 0, 7 * 128 + 127, 0, 0,
                             pfgb_pkg::STATUS_DONE));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            drive_item(script[i].rq, script[i].fixed, script[i].want);

        while (sent < ITEM_TARGET)
        begin
            steady = ((sent / 150) % 4 == 2);
            if (!held && sent >= 350)
            begin
                held = 1'b1;
                hold_asked++;
            end
            if (!paused && sent >= 700)
            begin
                paused = 1'b1;
                req_valid <= 1'b0;
                @(posedge clk);
                while (rsp_due.size() != 0)
                    @(posedge clk);
            end

            r    = noise_request();
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                r.req_type = pfgb_pkg::REQ_DRAW;
                pick = $urandom_range(0, 99);
                if (pick < 85)
                begin
                    r.pos_x     = 7'($urandom_range(0, pfgb_pkg::SCREEN_COLS - pfgb_pkg::CELL));
                    r.pos_y     = 6'($urandom_range(0, pfgb_pkg::SCREEN_ROWS - pfgb_pkg::CELL));
                    r.char_code = 8'($urandom_range(pfgb_pkg::FIRST_CODE,
                                     pfgb_pkg::FIRST_CODE + pfgb_pkg::FONT_GLYPHS - 1));
                end
                else if (pick < 93)
                begin
                    if ($urandom_range(0, 1))
                        r.pos_x = 7'($urandom_range(
                                     pfgb_pkg::SCREEN_COLS - pfgb_pkg::CELL + 1, 127));
                    else
                        r.pos_y = 6'($urandom_range(
                                     pfgb_pkg::SCREEN_ROWS - pfgb_pkg::CELL + 1, 63));
                end
                else
                begin
                    r.pos_x = 7'($urandom_range(0, pfgb_pkg::SCREEN_COLS - pfgb_pkg::CELL));
                    r.pos_y = 6'($urandom_range(0, pfgb_pkg::SCREEN_ROWS - pfgb_pkg::CELL));
                end
                if (r.pos_x <= pfgb_pkg::SCREEN_COLS - pfgb_pkg::CELL
                    && r.pos_y <= pfgb_pkg::SCREEN_ROWS - pfgb_pkg::CELL
                    && r.char_code >= pfgb_pkg::FIRST_CODE
                    && r.char_code < pfgb_pkg::FIRST_CODE + pfgb_pkg::FONT_GLYPHS)
                begin
                    // fill in any glyph column not loaded yet
                    for (int col = 0; col < pfgb_pkg::CELL; col++)
                    begin
                        idx = (r.char_code - pfgb_pkg::FIRST_CODE) * pfgb_pkg::CELL + col;
                        if (!font_written[idx])
                        begin
                            ld           = noise_request();
                            ld.req_type  = pfgb_pkg::REQ_LOAD;
                            ld.font_addr = 10'(idx);
                            drive_item(ld, 1'b0, '0);
                        end
                    end
                    last_base = (r.pos_y >> 3) * pfgb_pkg::SCREEN_COLS + r.pos_x;
                end
                drive_item(r, 1'b0, '0);
            end
            else if (kind < 70)
            begin
                r.req_type = pfgb_pkg::REQ_READ;
                if ($urandom_range(0, 1))
                    r.fb_addr = 10'((last_base + $urandom_range(0, pfgb_pkg::CELL - 1) +
                                     ($urandom_range(0, 1) ? pfgb_pkg::SCREEN_COLS : 0))
                                    % pfgb_pkg::STORE_DEPTH);
                drive_item(r, 1'b0, '0);
            end
            else if (kind < 95)
            begin
                r.req_type = pfgb_pkg::REQ_LOAD;
                drive_item(r, 1'b0, '0);
            end
            else
            begin
                r.req_type = REQ_UNUSED;
                drive_item(r, 1'b0, '0);
            end
        end

        req_valid <= 1'b0;
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && rsp_due.size() == 0)
            $display("page_framebuffer_glyph_blit_core_test: PASS");
        else
            $display("page_framebuffer_glyph_blit_core_test: FAIL");
        $finish;
    end

endmodule
